@@ rtl/core/fpagc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpagc_pkg
// Shared widths, constants and types of the frame peak gain control block.
// ----------------------------------------------------------------------------
package fpagc_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int GAIN_FRAC  = 8;
   localparam int ERR_W      = 32;
   localparam int ERR_FRAC   = 15;
   localparam int PEAK_W     = 24;
   localparam int LEV_W      = 17;
   localparam int LEV_SHIFT  = 15;
   localparam int DIFF_W     = PEAK_W + 1;
   localparam int STEP_SHIFT = 23;
   localparam int CFG_W      = 16;

   localparam int DIGIT_W    = 4;
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = 16;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int MUL_STEPS  = MUL_B_W / DIGIT_W;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

   localparam int DELTA_W    = PROD_W - STEP_SHIFT;
   localparam int GSUM_W     = DELTA_W + 1;

   localparam int CSR_IDX_W  = 3;

   localparam logic [GAIN_W-1:0]   GAIN_RESET     = 16'd256;
   localparam logic [CFG_W-1:0]    MAX_GAIN_RESET = 16'hFFFF;
   localparam logic [MUL_B_W-1:0]  ERR_KEEP       = 16'd29491;
   localparam logic [MUL_B_W-1:0]  ERR_NEW        = 16'd3277;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN     = 16'h8000;
   localparam logic [ERR_W-1:0]    ERR_MAX        = 32'h7FFF_FFFF;
   localparam logic [ERR_W-1:0]    ERR_MIN        = 32'h8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AGC_ENABLE   = 3'd0,
      CSR_ADAPT_STEP   = 3'd1,
      CSR_TARGET_LEVEL = 3'd2,
      CSR_MIN_GAIN     = 3'd3,
      CSR_MAX_GAIN     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             agc_enable;
      logic [CFG_W-1:0] adapt_step;
      logic [CFG_W-1:0] target_level;
      logic [CFG_W-1:0] min_gain;
      logic [CFG_W-1:0] max_gain;
      logic             enable_wr;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT,
      ST_MUL_SMP,
      ST_MUL_LEV,
      ST_MUL_KEEP,
      ST_MUL_NEW,
      ST_MUL_STEP
   } state_type;

   typedef enum logic [2:0] {
      MSEL_SAMPLE,
      MSEL_LEV,
      MSEL_KEEP,
      MSEL_NEW,
      MSEL_STEP
   } msel_type;

   typedef struct packed {
      logic     mul_start;
      msel_type mul_sel;
      logic     out_load;
      logic     out_pass;
      logic     smp_done;
      logic     lev_done;
      logic     keep_done;
      logic     new_done;
      logic     step_done;
   } ctl_type;

endpackage

@@ rtl/core/frame_peak_agc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_peak_agc
// Frame based peak gain control for 16-bit audio samples.
// ----------------------------------------------------------------------------
// Samples enter on the req_ stream (tdata = sample, tlast = last sample of a
// frame) and leave on the rsp_ stream, one result item per input item, with
// tlast copied. Registers are written through csr_we/csr_index/csr_wdata;
// the user must write them only while the block is idle, as the block does
// not enforce it. A write to the enable register clears the level error.
// With gain control on, a sample is multiplied by the gain in a shared
// 4-bit digit-serial multiplier and the result is registered when the
// multiplication is done; with gain control off the sample is registered
// unchanged. Either way the next item is taken only after the result is
// loaded into the output register. The last sample of a frame adds four more
// multiplications (target squared, the two error weights and the step)
// before the next item is taken.
// Reset restores unity gain, zero error and peak, and the register defaults.
// The result sits in an output register: a stalled receiver holds it there,
// and the block stops at the next result until that register frees.
// ----------------------------------------------------------------------------
module frame_peak_agc (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [fpagc_pkg::SAMPLE_W-1:0]       req_tdata,   // [15:0] sample_in
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fpagc_pkg::SAMPLE_W-1:0]       rsp_tdata,   // [15:0] sample_out
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [fpagc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fpagc_pkg::CFG_W-1:0]          csr_wdata
);
   import fpagc_pkg::*;

   cfg_type                    cfg;
   ctl_type                    ctl;
   state_type                  state_ff, state_in;

   logic                       take;
   logic                       out_free;
   logic                       mul_done;
   logic signed [PROD_W-1:0]   mul_prod;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic        [MUL_B_W-1:0]  mul_b;

   logic [SAMPLE_W-1:0]        smp_ff, smp_in;
   logic                       last_ff, last_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic [PEAK_W-1:0]          peak_ff, peak_in;
   logic [LEV_W-1:0]           lev_ff, lev_in;
   logic signed [PROD_W-1:0]   sum_ff, sum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic signed [SAMPLE_W:0]   smp_sx;
   logic [SAMPLE_W:0]          smp_abs;
   logic [PEAK_W-1:0]          mag;
   logic [PEAK_W-1:0]          neg_mag;
   logic [SAMPLE_W-1:0]        smp_res;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [PROD_W-1:0]   sum_all;
   logic signed [ERR_W:0]      e_wide;
   logic signed [ERR_W-1:0]    e_sat;
   logic signed [DELTA_W-1:0]  delta;
   logic signed [GSUM_W-1:0]   g_sum;
   logic [GAIN_W-1:0]          g_clamp;

   fpagc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fpagc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (ctl.mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign take       = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = cfg.agc_enable ? ST_MUL_SMP : ST_EMIT;
         ST_EMIT:     if (out_free) state_in = ST_IDLE;
         ST_MUL_SMP:  if (mul_done && out_free) state_in = last_ff ? ST_MUL_LEV : ST_IDLE;
         ST_MUL_LEV:  if (mul_done) state_in = ST_MUL_KEEP;
         ST_MUL_KEEP: if (mul_done) state_in = ST_MUL_NEW;
         ST_MUL_NEW:  if (mul_done) state_in = ST_MUL_STEP;
         ST_MUL_STEP: if (mul_done) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && cfg.agc_enable) begin
               ctl.mul_start = 1'b1;
               ctl.mul_sel   = MSEL_SAMPLE;
            end
         end
         ST_EMIT: begin
            ctl.out_load = out_free;
            ctl.out_pass = 1'b1;
         end
         ST_MUL_SMP: begin
            if (mul_done && out_free) begin
               ctl.out_load = 1'b1;
               ctl.smp_done = 1'b1;
               if (last_ff) begin
                  ctl.mul_start = 1'b1;
                  ctl.mul_sel   = MSEL_LEV;
               end
            end
         end
         ST_MUL_LEV: begin
            if (mul_done) begin
               ctl.lev_done  = 1'b1;
               ctl.mul_start = 1'b1;
               ctl.mul_sel   = MSEL_KEEP;
            end
         end
         ST_MUL_KEEP: begin
            if (mul_done) begin
               ctl.keep_done = 1'b1;
               ctl.mul_start = 1'b1;
               ctl.mul_sel   = MSEL_NEW;
            end
         end
         ST_MUL_NEW: begin
            if (mul_done) begin
               ctl.new_done  = 1'b1;
               ctl.mul_start = 1'b1;
               ctl.mul_sel   = MSEL_STEP;
            end
         end
         ST_MUL_STEP: begin
            ctl.step_done = mul_done;
         end
         default: ctl = '0;
      endcase
   end

   // ---------------- datapath ----------------
   assign smp_sx  = $signed({req_tdata[SAMPLE_W-1], req_tdata});
   assign smp_abs = smp_sx[SAMPLE_W] ? (SAMPLE_W+1)'(-smp_sx) : (SAMPLE_W+1)'(smp_sx);

   // magnitude of the gained sample, truncated toward zero
   assign mag     = mul_prod[PEAK_W+GAIN_FRAC-1:GAIN_FRAC];
   assign neg_mag = '0 - mag;

   always_comb begin
      if (smp_ff[SAMPLE_W-1]) begin
         if (mag > {{(PEAK_W-SAMPLE_W){1'b0}}, SAMPLE_MIN}) smp_res = SAMPLE_MIN;
         else smp_res = neg_mag[SAMPLE_W-1:0];
      end else begin
         if (mag > {{(PEAK_W-SAMPLE_W){1'b0}}, SAMPLE_MAX}) smp_res = SAMPLE_MAX;
         else smp_res = mag[SAMPLE_W-1:0];
      end
   end

   assign diff = $signed({{(DIFF_W-LEV_W){1'b0}}, lev_ff}) - $signed({1'b0, peak_ff});

   // new error: weighted sum, floor shift, saturate to 32 bits
   assign sum_all = sum_ff + mul_prod;
   assign e_wide  = $signed(sum_all[PROD_W-1:ERR_FRAC]);
   assign e_sat   = (e_wide[ERR_W] != e_wide[ERR_W-1]) ?
                    (e_wide[ERR_W] ? $signed(ERR_MIN) : $signed(ERR_MAX)) :
                    e_wide[ERR_W-1:0];

   assign delta = $signed(mul_prod[PROD_W-1:STEP_SHIFT]);
   assign g_sum = $signed({{(GSUM_W-GAIN_W){1'b0}}, gain_ff})
                + $signed({delta[DELTA_W-1], delta});

   always_comb begin
      priority if (g_sum < $signed({{(GSUM_W-CFG_W){1'b0}}, cfg.min_gain}))
         g_clamp = cfg.min_gain;
      else if (g_sum > $signed({{(GSUM_W-CFG_W){1'b0}}, cfg.max_gain}))
         g_clamp = cfg.max_gain;
      else
         g_clamp = g_sum[GAIN_W-1:0];
   end

   always_comb begin
      unique case (ctl.mul_sel)
         MSEL_SAMPLE: begin
            mul_a = {{(MUL_A_W-SAMPLE_W-1){1'b0}}, smp_abs};
            mul_b = gain_ff;
         end
         MSEL_LEV: begin
            mul_a = {{(MUL_A_W-CFG_W){1'b0}}, cfg.target_level};
            mul_b = cfg.target_level;
         end
         MSEL_KEEP: begin
            mul_a = err_ff;
            mul_b = ERR_KEEP;
         end
         MSEL_NEW: begin
            mul_a = {{(MUL_A_W-DIFF_W){diff[DIFF_W-1]}}, diff};
            mul_b = ERR_NEW;
         end
         MSEL_STEP: begin
            mul_a = e_sat;
            mul_b = cfg.adapt_step;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      smp_in  = take ? req_tdata : smp_ff;
      last_in = take ? req_tlast : last_ff;
      lev_in  = ctl.lev_done ? mul_prod[LEV_SHIFT+LEV_W-1:LEV_SHIFT] : lev_ff;
      sum_in  = ctl.keep_done ? mul_prod : sum_ff;

      gain_in = ctl.step_done ? g_clamp : gain_ff;

      err_in = err_ff;
      if (cfg.enable_wr) err_in = '0;
      else if (ctl.new_done) err_in = e_sat;

      peak_in = peak_ff;
      if (ctl.step_done) peak_in = '0;
      else if (ctl.smp_done && mag > peak_ff) peak_in = mag;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ctl.out_pass ? smp_ff : smp_res;
         rsp_last_in  = last_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_RESET;
         err_ff       <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         err_ff       <= err_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      smp_ff      <= smp_in;
      last_ff     <= last_in;
      lev_ff      <= lev_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_gain_clamped: assert property (@(posedge clock) disable iff (reset)
      ctl.step_done |=> (gain_ff >= $past(cfg.min_gain)) || (gain_ff == $past(cfg.max_gain)))
      else $error("gain left its clamp range");

   a_peak_cleared: assert property (@(posedge clock) disable iff (reset)
      ctl.step_done |=> peak_ff == '0)
      else $error("frame peak not cleared after update");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten while stalled");

   a_mul_start_when_free: assert property (@(posedge clock) disable iff (reset)
      (ctl.mul_start && state_ff != ST_IDLE) |-> mul_done)
      else $error("multiplier restarted while busy");

   a_bypass_holds_gain: assert property (@(posedge clock) disable iff (reset)
      (take && !cfg.agc_enable) |=> $stable(gain_ff) && state_ff == ST_EMIT)
      else $error("pass-through item moved the gain");

endmodule

@@ rtl/core/fpagc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpagc_mul
// Digit-serial multiplier: signed operand times unsigned operand, one
// multiplier digit per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module fpagc_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [fpagc_pkg::MUL_A_W-1:0]  op_a,
   input  logic        [fpagc_pkg::MUL_B_W-1:0]  op_b,
   output logic                                  done,
   output logic signed [fpagc_pkg::PROD_W-1:0]   prod
);
   import fpagc_pkg::*;

   logic signed [MUL_A_W-1:0]         a_ff, a_in;
   logic        [MUL_B_W-1:0]         b_ff, b_in;
   logic signed [PROD_W-1:0]          acc_ff, acc_in;
   logic        [MUL_CNT_W-1:0]       cnt_ff, cnt_in;
   logic                              run_ff, run_in;
   logic                              done_ff, done_in;
   logic signed [MUL_A_W+DIGIT_W:0]   part;
   logic signed [PROD_W-1:0]          part_ext;

   // partial product of the operand and the current digit
   assign part     = a_ff * $signed({1'b0, b_ff[MUL_B_W-1 -: DIGIT_W]});
   assign part_ext = {{(PROD_W-MUL_A_W-DIGIT_W-1){part[MUL_A_W+DIGIT_W]}}, part};

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         acc_in = (acc_ff <<< DIGIT_W) + part_ext;
         b_in   = b_ff << DIGIT_W;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_STEPS-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      start |=> !done_ff && run_ff)
      else $error("multiplier start did not clear done");

   a_run_excludes_done: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !done_ff)
      else $error("multiplier busy and done together");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(run_ff))
      else $error("multiplier done without a run");

   a_last_digit_finishes: assert property (@(posedge clock) disable iff (reset)
      (run_ff && !start && cnt_ff == MUL_CNT_W'(MUL_STEPS-1)) |=> done_ff && !run_ff)
      else $error("multiplier did not finish after its last digit");

endmodule

@@ rtl/core/fpagc_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpagc_csr
// Configuration registers of the gain control block, write only.
// ----------------------------------------------------------------------------
module fpagc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fpagc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fpagc_pkg::CFG_W-1:0]         csr_wdata,
   output fpagc_pkg::cfg_type                  cfg
);
   import fpagc_pkg::*;

   logic             enable_ff, enable_in;
   logic [CFG_W-1:0] step_ff, step_in;
   logic [CFG_W-1:0] target_ff, target_in;
   logic [CFG_W-1:0] min_ff, min_in;
   logic [CFG_W-1:0] max_ff, max_in;
   logic             enable_wr;

   always_comb begin
      enable_in = enable_ff;
      step_in   = step_ff;
      target_in = target_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      enable_wr = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_AGC_ENABLE: begin
               enable_in = csr_wdata[0];
               enable_wr = 1'b1;
            end
            CSR_ADAPT_STEP:   step_in   = csr_wdata;
            CSR_TARGET_LEVEL: target_in = csr_wdata;
            CSR_MIN_GAIN:     min_in    = csr_wdata;
            CSR_MAX_GAIN:     max_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         step_ff   <= '0;
         target_ff <= '0;
         min_ff    <= '0;
         max_ff    <= MAX_GAIN_RESET;
      end else begin
         enable_ff <= enable_in;
         step_ff   <= step_in;
         target_ff <= target_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
      end
   end

   assign cfg.agc_enable   = enable_ff;
   assign cfg.adapt_step   = step_ff;
   assign cfg.target_level = target_ff;
   assign cfg.min_gain     = min_ff;
   assign cfg.max_gain     = max_ff;
   assign cfg.enable_wr    = enable_wr;

   a_max_written: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == CSR_MAX_GAIN) |=> cfg.max_gain == $past(csr_wdata))
      else $error("max gain write lost");

   a_hold_without_write: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> $stable(enable_ff) && $stable(step_ff) && $stable(target_ff)
                  && $stable(min_ff) && $stable(max_ff))
      else $error("configuration moved without a write");

   a_enable_wr_needs_we: assert property (@(posedge clock) disable iff (reset)
      cfg.enable_wr |-> csr_we && csr_index == CSR_AGC_ENABLE)
      else $error("enable write strobe without a write");

endmodule
